### src/range_outlier_filter_alarm_core_defines.svh
// Assertion macros for the range outlier filter and alarm core.
`ifndef RANGE_OUTLIER_FILTER_ALARM_CORE_DEFINES_SVH
`define RANGE_OUTLIER_FILTER_ALARM_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// checked property, idle while reset is asserted
`define ROF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("range_outlier_filter_alarm_core: check failed");
// checked property, live through reset as well
`define ROF_ASSERT_NORST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("range_outlier_filter_alarm_core: check failed");
`else
`define ROF_ASSERT(lbl, clk, rst_n, prop)
`define ROF_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

### src/rof_pkg.sv
// Shared types and constants of the range outlier filter and alarm core.
package rof_pkg;

	localparam int RANGE_BITS_DEF = 14;
	localparam int CFG_ADDR_W     = 5;
	localparam int PRODUCT_W      = 48;

	localparam int unsigned MS_PER_S    = 1000;
	localparam logic [31:0] DROP_MIN_MS = 32'd100;

	typedef enum logic [2:0] {
		ST_FAILED = 3'd0,
		ST_WARMUP = 3'd1,
		ST_FIRST  = 3'd2,
		ST_NORMAL = 3'd3,
		ST_HELD   = 3'd4,
		ST_FORCED = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REG_MIN_VALID   = 3'd0,
		REG_WARMUP      = 3'd1,
		REG_JUMP_LIMIT  = 3'd2,
		REG_JUMP_RATE   = 3'd3,
		REG_MAX_BAD_RUN = 3'd4,
		REG_DANGER      = 3'd5,
		REG_DROP_RATE   = 3'd6,
		REG_DROP_WINDOW = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [13:0] min_valid_distance;
		logic [2:0]  warmup_samples;
		logic [13:0] jump_limit;
		logic [15:0] jump_rate_limit;
		logic [1:0]  max_bad_run;
		logic [13:0] alarm_floor;
		logic [15:0] drop_rate_limit;
		logic [15:0] drop_window_max_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		min_valid_distance: 14'd368,
		warmup_samples:     3'd5,
		jump_limit:         14'd480,
		jump_rate_limit:    16'd320,
		max_bad_run:        2'd2,
		alarm_floor:        14'd800,
		drop_rate_limit:    16'd240,
		drop_window_max_ms: 16'd5000
	};

	typedef struct packed {
		status_t status;
		logic    alarm;
	} rof_res_t;

endpackage

### src/rof_in_if.sv
// Reading channel: valid/ready handshake carrying one range reading word.
interface rof_in_if import rof_pkg::*; #(
	parameter int RANGE_BITS = RANGE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  sample_ok;
	logic [RANGE_BITS-1:0] range_in;
	logic [31:0]           time_ms;

	modport source (output valid, output sample_ok, output range_in, output time_ms,
		input ready);
	modport sink (input valid, input sample_ok, input range_in, input time_ms,
		output ready);
endinterface

### src/rof_out_if.sv
// Result channel: valid/ready handshake carrying one filtered result word.
interface rof_out_if import rof_pkg::*; #(
	parameter int RANGE_BITS = RANGE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [2:0]            status;
	logic [RANGE_BITS-1:0] range_out;
	logic                  roof_alarm;

	modport source (output valid, output status, output range_out, output roof_alarm,
		input ready);
	modport sink (input valid, input status, input range_out, input roof_alarm,
		output ready);
endinterface

### src/range_outlier_filter_alarm_core.sv
// Top level of the range outlier filter and roof alarm core.
// Takes one range reading word per cycle unless the result side stalls, and returns
// one result word for each, in order. A reading is registered on acceptance, judged
// against the filter state by 16x32 rate multiplies and compares, and lands in the
// output register once that register is free; a new reading can be accepted every
// cycle while the result side keeps up. Throughput is set by the single filter state
// update per cycle. Configuration is to be written over the APB port only while no
// reading is in flight; the core itself does not enforce this.
`include "range_outlier_filter_alarm_core_defines.svh"
module range_outlier_filter_alarm_core import rof_pkg::*; #(
	parameter int RANGE_BITS = RANGE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	rof_in_if.sink                reading,
	rof_out_if.source             result
);
	cfg_t                  cfg;
	rof_res_t              res;
	logic [RANGE_BITS-1:0] range_res;

	logic                  valid_s1;
	logic                  ok_s1;
	logic [RANGE_BITS-1:0] range_s1;
	logic [31:0]           time_s1;

	logic                  valid_s2;
	status_t               status_s2;
	logic [RANGE_BITS-1:0] range_s2;
	logic                  alarm_s2;

	logic                  advance;
	logic                  fire;
	logic                  take;

	assign advance       = !valid_s2 || result.ready;
	assign fire          = valid_s1 && advance;
	assign reading.ready = !valid_s1 || advance;
	assign take          = reading.valid && reading.ready;

	rof_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rof_filter #(
		.RANGE_BITS (RANGE_BITS)
	) u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fire      (fire),
		.sample_ok (ok_s1),
		.range_in  (range_s1),
		.time_ms   (time_s1),
		.res       (res),
		.range_out (range_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ok_s1    <= reading.sample_ok;
			range_s1 <= reading.range_in;
			time_s1  <= reading.time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= res.status;
			range_s2  <= range_res;
			alarm_s2  <= res.alarm;
		end
	end

	assign result.valid      = valid_s2;
	assign result.status     = status_s2;
	assign result.range_out  = range_s2;
	assign result.roof_alarm = alarm_s2;

	`ROF_ASSERT(a_take_fills_s1, clk, arst_n, take |=> valid_s1)
	`ROF_ASSERT(a_no_overwrite, clk, arst_n, (valid_s2 && !result.ready) |-> !fire)
	`ROF_ASSERT_NORST(a_warmup_quiet, clk,
		(result.valid && (result.status == ST_WARMUP)) |-> !result.roof_alarm)
endmodule

### src/rof_apb_regs.sv
// APB configuration register bank of the range outlier filter.
module rof_apb_regs import rof_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);
	cfg_t     cfg_q;
	cfg_idx_t idx;
	logic     wr_en;

	assign idx    = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_MIN_VALID:   cfg_q.min_valid_distance <= pwdata[13:0];
				REG_WARMUP:      cfg_q.warmup_samples     <= pwdata[2:0];
				REG_JUMP_LIMIT:  cfg_q.jump_limit         <= pwdata[13:0];
				REG_JUMP_RATE:   cfg_q.jump_rate_limit    <= pwdata[15:0];
				REG_MAX_BAD_RUN: cfg_q.max_bad_run        <= pwdata[1:0];
				REG_DANGER:      cfg_q.alarm_floor        <= pwdata[13:0];
				REG_DROP_RATE:   cfg_q.drop_rate_limit    <= pwdata[15:0];
				REG_DROP_WINDOW: cfg_q.drop_window_max_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MIN_VALID:   prdata = 32'(cfg_q.min_valid_distance);
			REG_WARMUP:      prdata = 32'(cfg_q.warmup_samples);
			REG_JUMP_LIMIT:  prdata = 32'(cfg_q.jump_limit);
			REG_JUMP_RATE:   prdata = 32'(cfg_q.jump_rate_limit);
			REG_MAX_BAD_RUN: prdata = 32'(cfg_q.max_bad_run);
			REG_DANGER:      prdata = 32'(cfg_q.alarm_floor);
			REG_DROP_RATE:   prdata = 32'(cfg_q.drop_rate_limit);
			REG_DROP_WINDOW: prdata = 32'(cfg_q.drop_window_max_ms);
			default:         prdata = '0;
		endcase
	end
endmodule

### src/rof_filter.sv
// Filter state and combinational decision logic for one reading.
module rof_filter import rof_pkg::*; #(
	parameter int RANGE_BITS = RANGE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  fire,
	input  logic                  sample_ok,
	input  logic [RANGE_BITS-1:0] range_in,
	input  logic [31:0]           time_ms,
	output rof_res_t              res,
	output logic [RANGE_BITS-1:0] range_out
);
	localparam int CW = (RANGE_BITS > 14) ? RANGE_BITS : 14;

	logic [2:0]            warmup_cnt_q;
	logic [2:0]            bad_run_q;
	logic                  have_good_q;
	logic [RANGE_BITS-1:0] good_range_q;
	logic [31:0]           good_time_q;
	logic                  alarm_q;

	logic                  failed;
	logic                  in_warmup;
	logic [31:0]           dt;
	logic [RANGE_BITS-1:0] step;
	logic [PRODUCT_W-1:0]  step_scaled;
	logic [PRODUCT_W-1:0]  jump_allow;
	logic                  rejected;
	logic [2:0]            run_inc;
	logic                  held;
	logic [RANGE_BITS-1:0] result_rng;
	logic [RANGE_BITS-1:0] drop;
	logic [PRODUCT_W-1:0]  drop_scaled;
	logic [PRODUCT_W-1:0]  drop_allow;
	logic                  danger;

	always_comb begin
		failed      = !sample_ok || (CW'(range_in) < CW'(cfg.min_valid_distance));
		in_warmup   = warmup_cnt_q < cfg.warmup_samples;
		dt          = time_ms - good_time_q;
		step        = (range_in >= good_range_q) ? (range_in - good_range_q)
			: (good_range_q - range_in);
		step_scaled = PRODUCT_W'(step) * PRODUCT_W'(MS_PER_S);
		jump_allow  = PRODUCT_W'(cfg.jump_rate_limit) * PRODUCT_W'(dt);
		rejected    = have_good_q &&
			((CW'(step) > CW'(cfg.jump_limit)) || (step_scaled > jump_allow));
		run_inc     = (bad_run_q == 3'd7) ? bad_run_q : bad_run_q + 3'd1;
		held        = rejected && (run_inc <= 3'(cfg.max_bad_run));
		result_rng  = held ? good_range_q : range_in;
		drop        = good_range_q - result_rng;
		drop_scaled = PRODUCT_W'(drop) * PRODUCT_W'(MS_PER_S);
		drop_allow  = PRODUCT_W'(cfg.drop_rate_limit) * PRODUCT_W'(dt);
		// drop rate is judged against the good sample held before this update
		danger      = (CW'(result_rng) < CW'(cfg.alarm_floor)) ||
			(have_good_q && (dt > DROP_MIN_MS) && (dt < 32'(cfg.drop_window_max_ms)) &&
			(good_range_q > result_rng) && (drop_scaled > drop_allow));

		if (failed) begin
			res.status = ST_FAILED;
			res.alarm  = alarm_q;
			range_out  = range_in;
		end else if (in_warmup) begin
			res.status = ST_WARMUP;
			res.alarm  = 1'b0;
			range_out  = range_in;
		end else begin
			if (!have_good_q) begin
				res.status = ST_FIRST;
			end else if (held) begin
				res.status = ST_HELD;
			end else if (rejected) begin
				res.status = ST_FORCED;
			end else begin
				res.status = ST_NORMAL;
			end
			res.alarm = danger;
			range_out = result_rng;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_cnt_q <= '0;
			bad_run_q    <= '0;
			have_good_q  <= 1'b0;
			good_range_q <= '0;
			good_time_q  <= '0;
			alarm_q      <= 1'b0;
		end else if (fire && !failed) begin
			if (in_warmup) begin
				warmup_cnt_q <= warmup_cnt_q + 3'd1;
				alarm_q      <= 1'b0;
			end else begin
				alarm_q     <= danger;
				have_good_q <= 1'b1;
				if (held) begin
					bad_run_q <= run_inc;
				end else begin
					bad_run_q    <= '0;
					good_range_q <= range_in;
					good_time_q  <= time_ms;
				end
			end
		end
	end
endmodule
